// File: design/phcc_pkg.sv
// Shared types and constants for the pump hysteresis cooldown controller.
package phcc_pkg;

  localparam int MOIST_W = 10;
  localparam int TIME_W  = 32;
  localparam int STAT_W  = 2;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_READ_ERR = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_INVALID  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_ON_THR   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_OFF_THR  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COOLDOWN = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DROP_LIM = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WIN_LEN  = 3'd4;

  localparam logic [MOIST_W-1:0] ON_THR_RST   = 10'd350;
  localparam logic [MOIST_W-1:0] OFF_THR_RST  = 10'd550;
  localparam logic [TIME_W-1:0]  COOLDOWN_RST = 32'd43200000;
  localparam logic [MOIST_W-1:0] DROP_LIM_RST = 10'd150;
  localparam logic [TIME_W-1:0]  WIN_LEN_RST  = 32'd14400000;

  typedef struct packed {
    logic [MOIST_W-1:0] on_threshold;
    logic [MOIST_W-1:0] off_threshold;
    logic [TIME_W-1:0]  cooldown_time;
    logic [MOIST_W-1:0] drop_limit;
    logic [TIME_W-1:0]  window_length;
  } cfg_t;

  typedef struct packed {
    logic               pump;
    logic [TIME_W-1:0]  last_off;
    logic [TIME_W-1:0]  win_time;
    logic [MOIST_W-1:0] win_moist;
    logic               anomaly;
  } state_t;

  typedef struct packed {
    logic               read_ok;
    logic               reading_valid;
    logic [MOIST_W-1:0] moisture;
    logic [TIME_W-1:0]  now_time;
  } sample_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              pump_on;
    logic              toggled;
    logic              cooldown_active;
    logic              anomaly;
  } result_t;

endpackage

// File: design/phcc_step.sv
// Next-state and result logic for one moisture sample.
module phcc_step (
  input  phcc_pkg::cfg_t    cfg,
  input  phcc_pkg::state_t  st,
  input  phcc_pkg::sample_t smp,
  output phcc_pkg::state_t  st_next,
  output phcc_pkg::result_t res
);

  logic [phcc_pkg::TIME_W-1:0]  win_age;
  logic [phcc_pkg::TIME_W-1:0]  off_age;
  logic [phcc_pkg::MOIST_W:0]   drop_floor;
  logic                         win_elapsed;
  logic                         dropped;
  logic                         locked;

  assign win_age     = smp.now_time - st.win_time;
  assign off_age     = smp.now_time - st.last_off;
  assign win_elapsed = (win_age >= cfg.window_length);
  // The drop reaches the limit when start >= level + limit; no sign handling needed.
  assign drop_floor  = {1'b0, smp.moisture} + {1'b0, cfg.drop_limit};
  assign dropped     = ({1'b0, st.win_moist} >= drop_floor);
  assign locked      = (st.last_off != '0) && (off_age < cfg.cooldown_time);

  always_comb begin
    st_next             = st;
    res.status          = phcc_pkg::STATUS_OK;
    res.toggled         = 1'b0;
    res.cooldown_active = 1'b0;
    if (!smp.read_ok) begin
      res.status = phcc_pkg::STATUS_READ_ERR;
    end else if (!smp.reading_valid) begin
      res.status   = phcc_pkg::STATUS_INVALID;
      st_next.pump = 1'b0;
    end else begin
      if (st.win_time == '0) begin
        st_next.win_time  = smp.now_time;
        st_next.win_moist = smp.moisture;
      end else if (win_elapsed) begin
        if (dropped) begin
          st_next.anomaly = 1'b1;
        end
        st_next.win_time  = smp.now_time;
        st_next.win_moist = smp.moisture;
      end
      if (!st.pump) begin
        if (smp.moisture < cfg.on_threshold) begin
          if (locked) begin
            res.cooldown_active = 1'b1;
          end else begin
            st_next.pump = 1'b1;
            res.toggled  = 1'b1;
          end
        end
      end else if (smp.moisture >= cfg.off_threshold) begin
        st_next.pump     = 1'b0;
        st_next.last_off = smp.now_time;
        res.toggled      = 1'b1;
      end
    end
    res.pump_on = st_next.pump;
    res.anomaly = st_next.anomaly;
  end

endmodule

// File: design/pump_hysteresis_cooldown_controller_top.sv
// Top level of the pump hysteresis controller with restart lockout and anomaly flag.
// An accepted transaction is held in the sample register, then its result in the result
// register. One transaction per cycle unless the output side stalls; the two registers
// each hold one item, and the controller state is updated by the single step stage.
// Reset (rst, synchronous, active high) turns the pump off, clears the switch-off time,
// the observation window and the anomaly flag, and loads the register reset values.
module pump_hysteresis_cooldown_controller_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              read_ok,
  input  logic                              reading_valid,
  input  logic [phcc_pkg::MOIST_W-1:0]      moisture,
  input  logic [phcc_pkg::TIME_W-1:0]       now_time,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [phcc_pkg::STAT_W-1:0]       status,
  output logic                              pump_on,
  output logic                              toggled,
  output logic                              cooldown_active,
  output logic                              anomaly,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [phcc_pkg::ADDR_W-1:0]       paddr,
  input  logic [phcc_pkg::DATA_W-1:0]       pwdata,
  output logic [phcc_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  // APB port config registers; the user writes them only while the block is idle, unchecked.
  phcc_pkg::cfg_t    cfg;
  // Controller state that carries from one sample to the next.
  phcc_pkg::state_t  st;
  phcc_pkg::state_t  st_next;
  // Sample register: the first stage holds the accepted transaction.
  phcc_pkg::sample_t smp;
  logic              smp_valid;
  phcc_pkg::result_t res_next;
  phcc_pkg::result_t res;

  logic                          advance;
  logic                          cfg_wr;
  logic [phcc_pkg::REG_IDX_W-1:0] reg_idx;

  // The result register can take a new item when it is empty or being drained.
  // The sample register refills whenever it is empty or moves on, so a new
  // transaction is accepted every cycle unless the output side stalls.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !smp_valid || advance;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[phcc_pkg::ADDR_W-1:2];

  always_comb begin
    case (reg_idx)
      phcc_pkg::REG_ON_THR:   prdata = {{(phcc_pkg::DATA_W-phcc_pkg::MOIST_W){1'b0}},
                                        cfg.on_threshold};
      phcc_pkg::REG_OFF_THR:  prdata = {{(phcc_pkg::DATA_W-phcc_pkg::MOIST_W){1'b0}},
                                        cfg.off_threshold};
      phcc_pkg::REG_COOLDOWN: prdata = cfg.cooldown_time;
      phcc_pkg::REG_DROP_LIM: prdata = {{(phcc_pkg::DATA_W-phcc_pkg::MOIST_W){1'b0}},
                                        cfg.drop_limit};
      phcc_pkg::REG_WIN_LEN:  prdata = cfg.window_length;
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on_threshold  <= phcc_pkg::ON_THR_RST;
      cfg.off_threshold <= phcc_pkg::OFF_THR_RST;
      cfg.cooldown_time <= phcc_pkg::COOLDOWN_RST;
      cfg.drop_limit    <= phcc_pkg::DROP_LIM_RST;
      cfg.window_length <= phcc_pkg::WIN_LEN_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        phcc_pkg::REG_ON_THR:   cfg.on_threshold  <= pwdata[phcc_pkg::MOIST_W-1:0];
        phcc_pkg::REG_OFF_THR:  cfg.off_threshold <= pwdata[phcc_pkg::MOIST_W-1:0];
        phcc_pkg::REG_COOLDOWN: cfg.cooldown_time <= pwdata[phcc_pkg::TIME_W-1:0];
        phcc_pkg::REG_DROP_LIM: cfg.drop_limit    <= pwdata[phcc_pkg::MOIST_W-1:0];
        phcc_pkg::REG_WIN_LEN:  cfg.window_length <= pwdata[phcc_pkg::TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The sample payload needs no reset; smp_valid guards it.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp.read_ok       <= read_ok;
      smp.reading_valid <= reading_valid;
      smp.moisture      <= moisture;
      smp.now_time      <= now_time;
    end
  end

  phcc_step u_step (
    .cfg     (cfg),
    .st      (st),
    .smp     (smp),
    .st_next (st_next),
    .res     (res_next)
  );

  // The state advances exactly when a sample moves into the result register,
  // so each sample sees the state left by the one before it.
  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid    <= 1'b0;
      out_valid    <= 1'b0;
      st.pump      <= 1'b0;
      st.last_off  <= '0;
      st.win_time  <= '0;
      st.win_moist <= '0;
      st.anomaly   <= 1'b0;
    end else begin
      if (in_ready) begin
        smp_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= smp_valid;
        if (smp_valid) begin
          st <= st_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && smp_valid) begin
      res <= res_next;
    end
  end

  assign status          = res.status;
  assign pump_on         = res.pump_on;
  assign toggled         = res.toggled;
  assign cooldown_active = res.cooldown_active;
  assign anomaly         = res.anomaly;

  // A single sample can either switch the pump or be held off by the lockout.
  a_toggle_or_lock: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(toggled && cooldown_active))
    else $error("toggled and cooldown_active both set");

  // Read errors and invalid readings never switch the pump or report a lockout.
  a_fault_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != phcc_pkg::STATUS_OK) |-> (!toggled && !cooldown_active))
    else $error("fault status with switch or lockout flag");

  // An invalid reading always leaves the pump off.
  a_invalid_off: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == phcc_pkg::STATUS_INVALID) |-> !pump_on)
    else $error("pump on after invalid reading");

  // The anomaly flag is sticky until reset.
  a_anomaly_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(st.anomaly) |-> st.anomaly)
    else $error("anomaly flag cleared without reset");

  // A full sample register behind a stalled result register blocks new input.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (smp_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while pipeline is stalled");

endmodule

// File: verif/tb_pump_hysteresis_cooldown_controller_top.sv
// Self-checking testbench for the pump hysteresis controller with restart lockout.
`timescale 1ns / 1ps

module tb_pump_hysteresis_cooldown_controller_top;

  // Pump state prediction and result checking. The controller state and the register
  // settings are mirrored here, so every accepted sample yields exactly one expected
  // result, which is queued until the block delivers its own.
  class pump_result_checker;
    phcc_pkg::cfg_t    cfg;
    phcc_pkg::state_t  st;
    phcc_pkg::result_t expected_results[$];
    int                mismatch_count;
    int                checked_count;
    int                toggle_count;

    function new();
      cfg.on_threshold  = phcc_pkg::ON_THR_RST;
      cfg.off_threshold = phcc_pkg::OFF_THR_RST;
      cfg.cooldown_time = phcc_pkg::COOLDOWN_RST;
      cfg.drop_limit    = phcc_pkg::DROP_LIM_RST;
      cfg.window_length = phcc_pkg::WIN_LEN_RST;
      st = '0;
      mismatch_count = 0;
      checked_count = 0;
      toggle_count = 0;
    endfunction

    function void set_reg(logic [phcc_pkg::REG_IDX_W-1:0] idx,
                          logic [phcc_pkg::DATA_W-1:0] value);
      case (idx)
        phcc_pkg::REG_ON_THR:   cfg.on_threshold  = value[phcc_pkg::MOIST_W-1:0];
        phcc_pkg::REG_OFF_THR:  cfg.off_threshold = value[phcc_pkg::MOIST_W-1:0];
        phcc_pkg::REG_COOLDOWN: cfg.cooldown_time = value[phcc_pkg::TIME_W-1:0];
        phcc_pkg::REG_DROP_LIM: cfg.drop_limit    = value[phcc_pkg::MOIST_W-1:0];
        phcc_pkg::REG_WIN_LEN:  cfg.window_length = value[phcc_pkg::TIME_W-1:0];
        default: ;
      endcase
    endfunction

    // Advances the mirrored controller by one accepted sample.
    function void note_sample(phcc_pkg::sample_t s);
      phcc_pkg::result_t           r;
      logic [phcc_pkg::TIME_W-1:0] since;
      int                          fall;
      r = '0;
      r.status = phcc_pkg::STATUS_OK;
      if (!s.read_ok) begin
        r.status = phcc_pkg::STATUS_READ_ERR;
      end else if (!s.reading_valid) begin
        r.status = phcc_pkg::STATUS_INVALID;
        st.pump = 1'b0;
      end else begin
        // A window start time of zero means no window is open yet.
        if (st.win_time == '0) begin
          st.win_time  = s.now_time;
          st.win_moist = s.moisture;
        end else begin
          since = s.now_time - st.win_time;
          if (since >= cfg.window_length) begin
            fall = int'(st.win_moist) - int'(s.moisture);
            if (fall >= int'(cfg.drop_limit)) st.anomaly = 1'b1;
            st.win_time  = s.now_time;
            st.win_moist = s.moisture;
          end
        end
        if (!st.pump) begin
          if (s.moisture < cfg.on_threshold) begin
            since = s.now_time - st.last_off;
            if (st.last_off != '0 && since < cfg.cooldown_time) begin
              r.cooldown_active = 1'b1;
            end else begin
              st.pump = 1'b1;
              r.toggled = 1'b1;
            end
          end
        end else if (s.moisture >= cfg.off_threshold) begin
          st.pump = 1'b0;
          st.last_off = s.now_time;
          r.toggled = 1'b1;
        end
      end
      r.pump_on = st.pump;
      r.anomaly = st.anomaly;
      expected_results.push_back(r);
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    endfunction

    function void check_result(phcc_pkg::result_t got);
      phcc_pkg::result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, actual %b", $time, got);
        mismatch_count++;
        return;
      end
      want = expected_results.pop_front();
      checked_count++;
      if (got.toggled === 1'b1) toggle_count++;
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.pump_on !== want.pump_on) report("pump_on", want.pump_on, got.pump_on);
      if (got.toggled !== want.toggled) report("toggled", want.toggled, got.toggled);
      if (got.cooldown_active !== want.cooldown_active)
        report("cooldown_active", want.cooldown_active, got.cooldown_active);
      if (got.anomaly !== want.anomaly) report("anomaly", want.anomaly, got.anomaly);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  localparam int PHASES       = 7;
  localparam int PHASE_ITEMS  = 118;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          in_valid;
  logic                          in_ready;
  logic                          read_ok;
  logic                          reading_valid;
  logic [phcc_pkg::MOIST_W-1:0]  moisture;
  logic [phcc_pkg::TIME_W-1:0]   now_time;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [phcc_pkg::STAT_W-1:0]   status;
  logic                          pump_on;
  logic                          toggled;
  logic                          cooldown_active;
  logic                          anomaly;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [phcc_pkg::ADDR_W-1:0]   paddr;
  logic [phcc_pkg::DATA_W-1:0]   pwdata;
  logic [phcc_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  pump_result_checker ledger;

  // Idle controls for the two sides; the main sequence switches them per stretch.
  bit                          src_idle_en  = 1'b0;
  bit                          sink_stall_en = 1'b0;
  int                          sink_hold = 0;
  int                          sent_count = 0;
  int                          setting_count = 0;
  logic [phcc_pkg::TIME_W-1:0] cur_time = '0;

  pump_hysteresis_cooldown_controller_top u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .read_ok         (read_ok),
    .reading_valid   (reading_valid),
    .moisture        (moisture),
    .now_time        (now_time),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .pump_on         (pump_on),
    .toggled         (toggled),
    .cooldown_active (cooldown_active),
    .anomaly         (anomaly),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #1 clk = ~clk;

  // Hard limit on the run, far beyond the slowest legal completion.
  initial begin
    #1000000;
    $display("Test completed with failures");
    $finish;
  end

  // Idle lengths: mostly back to back or a short pause, now and then a long one.
  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side. A result transaction completes on an edge where out_valid and
  // out_ready were both high; the checker sees the values held before that edge.
  // out_ready is then updated for the next cycle, with random stall bursts when
  // stalling is enabled.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      ledger.check_result({status, pump_on, toggled, cooldown_active, anomaly});
    if (sink_hold > 0) begin
      sink_hold = sink_hold - 1;
      out_ready <= 1'b0;
    end else if (sink_stall_en && $urandom_range(0, 3) == 0) begin
      sink_hold = pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offers one sample and holds it until the block takes it. in_valid stays high
  // when no gap follows, so back-to-back transactions never drop valid in between.
  task automatic send_sample(input phcc_pkg::sample_t s);
    int gap;
    in_valid      <= 1'b1;
    read_ok       <= s.read_ok;
    reading_valid <= s.reading_valid;
    moisture      <= s.moisture;
    now_time      <= s.now_time;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ledger.note_sample(s);
    sent_count++;
    gap = src_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drive_reading(input logic ok, input logic valid,
                               input logic [phcc_pkg::MOIST_W-1:0] level,
                               input logic [phcc_pkg::TIME_W-1:0] stamp);
    phcc_pkg::sample_t s;
    s.read_ok       = ok;
    s.reading_valid = valid;
    s.moisture      = level;
    s.now_time      = stamp;
    send_sample(s);
  endtask

  // Drops valid and waits until every expected result has been delivered.
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write: a setup cycle, then the access cycle that commits.
  task automatic write_reg(input logic [phcc_pkg::REG_IDX_W-1:0] idx,
                           input logic [phcc_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    ledger.set_reg(idx, value);
  endtask

  task automatic apply_settings(input int unsigned on_thr, input int unsigned off_thr,
                                input int unsigned cooldown, input int unsigned drop_lim,
                                input int unsigned win_len);
    write_reg(phcc_pkg::REG_ON_THR, on_thr);
    write_reg(phcc_pkg::REG_OFF_THR, off_thr);
    write_reg(phcc_pkg::REG_COOLDOWN, cooldown);
    write_reg(phcc_pkg::REG_DROP_LIM, drop_lim);
    write_reg(phcc_pkg::REG_WIN_LEN, win_len);
    setting_count++;
  endtask

  // One random sample. Time mostly creeps forward by a phase-dependent step so
  // that windows and lockouts actually expire; occasionally it jumps anywhere,
  // sits just below the wrap point, or reads zero. Moisture is either uniform over
  // the full 10-bit field or lands within a couple of counts of a threshold.
  task automatic send_random_item(input int unsigned step_max);
    int unsigned       roll;
    int                level;
    phcc_pkg::sample_t s;
    roll = $urandom_range(0, 99);
    if (roll < 3)
      cur_time = $urandom();
    else if (roll < 5)
      cur_time = 32'hFFFF_FFFF - $urandom_range(0, step_max);
    else if (roll < 7)
      cur_time = '0;
    else
      cur_time = cur_time + $urandom_range(0, step_max);
    s.now_time = cur_time;
    roll = $urandom_range(0, 99);
    s.read_ok       = (roll >= 5);
    s.reading_valid = (roll >= 10) || (roll < 5 && $urandom_range(0, 1) == 1);
    if ($urandom_range(0, 99) < 25) begin
      if ($urandom_range(0, 1) == 1)
        level = int'(ledger.cfg.on_threshold);
      else
        level = int'(ledger.cfg.off_threshold);
      level = level + int'($urandom_range(0, 4)) - 2;
      if (level < 0) level = 0;
      if (level > 1023) level = 1023;
    end else begin
      level = $urandom_range(0, 1023);
    end
    s.moisture = level[phcc_pkg::MOIST_W-1:0];
    send_sample(s);
  endtask

  initial begin
    int unsigned step_max;
    int          guard;

    ledger = new();
    in_valid      <= 1'b0;
    read_ok       <= 1'b0;
    reading_valid <= 1'b0;
    moisture      <= '0;
    now_time      <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rst           <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed samples under the reset register values (on 350, off 550,
    // 12 h cooldown, drop limit 150, 4 h window).
    src_idle_en   = 1'b1;
    sink_stall_en = 1'b1;
    drive_reading(1'b0, 1'b1, 10'd200, 32'd5000);       // read error straight after reset
    drive_reading(1'b1, 1'b1, 10'd1023, 32'd0);         // time zero cannot open the window
    drive_reading(1'b1, 1'b0, 10'd0, 32'd100);          // invalid reading with the pump off
    drive_reading(1'b1, 1'b1, 10'd350, 32'd1000);       // exactly at the switch-on level
    drive_reading(1'b1, 1'b1, 10'd349, 32'd2000);       // just below it: pump starts
    drive_reading(1'b1, 1'b1, 10'd549, 32'd3000);       // just below switch-off
    drive_reading(1'b1, 1'b1, 10'd550, 32'd4000);       // switch-off, lockout begins
    drive_reading(1'b1, 1'b1, 10'd0, 32'd5000);         // dry but locked out
    drive_reading(1'b1, 1'b1, 10'd201, 32'd14401000);   // window elapses, drop one short
    drive_reading(1'b1, 1'b1, 10'd100, 32'd43203999);   // last millisecond of lockout
    drive_reading(1'b1, 1'b1, 10'd100, 32'd43204000);   // lockout over: pump starts
    drive_reading(1'b1, 1'b0, 10'd1023, 32'd43210000);  // invalid forces the pump off
    drive_reading(1'b0, 1'b0, 10'd0, 32'd0);            // read error with every field low
    drive_reading(1'b1, 1'b1, 10'd300, 32'd43220000);   // restart, switch-off time untouched
    drive_reading(1'b1, 1'b1, 10'd1023, 32'd0);         // switch-off at time zero
    drive_reading(1'b1, 1'b1, 10'd0, 32'hFFFF_FFFF);    // no lockout after that, window reopens
    drive_reading(1'b1, 1'b1, 10'd700, 32'd5);          // switch-off across the wrap
    drive_reading(1'b1, 1'b1, 10'd0, 32'd4);            // backwards time reads as a huge gap
    drive_reading(1'b1, 1'b1, 10'd1023, 32'd14399999);  // window exactly elapsed over the wrap
    drive_reading(1'b1, 1'b1, 10'd875, 32'd28799999);   // drop of 148 stays below the limit
    drive_reading(1'b1, 1'b1, 10'd0, 32'd28800000);     // locked out again
    drain_block();

    // Random phases, each under its own register setting. The anomaly flag is sticky
    // and reset comes only once, so every phase but the last uses the widest drop
    // limit and the flag is raised on purpose at the start of the last phase.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin apply_settings(350, 550, 1000, 1023, 300); step_max = 200; end
        1: begin apply_settings(0, 0, 0, 1023, 0); step_max = 50; end
        2: begin
          apply_settings(1023, 1023, 32'hFFFF_FFFF, 1023, 32'hFFFF_FFFF);
          step_max = 1000;
        end
        3: begin apply_settings(600, 400, 50, 1023, 100); step_max = 40; end
        4: begin
          apply_settings($urandom_range(0, 1023), $urandom_range(0, 1023),
                         $urandom_range(0, 3000), 1023, $urandom_range(0, 3000));
          step_max = 500;
        end
        5: begin apply_settings(1000, 1000, 1, 1023, 1); step_max = 3; end
        default: begin
          apply_settings(350, 550, 43200000, 0, 0);
          step_max = 2000000;
          // With a zero-length window every sample compares with the one before it:
          // a rise of one leaves the flag clear, an equal level meets a zero limit.
          drive_reading(1'b1, 1'b1, 10'd600, 32'd1000);
          drive_reading(1'b1, 1'b1, 10'd601, 32'd1001);
          drive_reading(1'b1, 1'b1, 10'd601, 32'd1002);
          cur_time = 32'd1002;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // The first phase and every third stretch of 40 run without any idling.
        src_idle_en   = (phase != 0) && ((n / 40) % 3 != 2);
        sink_stall_en = src_idle_en;
        send_random_item(step_max);
        // Occasionally hold the sender back until the block has delivered everything.
        if (n == 60 || $urandom_range(0, 99) == 0) drain_block();
      end
      drain_block();
    end

    guard = 0;
    while (ledger.pending() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (6) @(posedge clk);

    if (ledger.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, ledger.pending());
      ledger.mismatch_count += ledger.pending();
    end
    $display("Ran %0d samples over the reset values and %0d register settings.",
             sent_count, setting_count);
    $display("Checked %0d results, %0d of them pump switches, with %0d mismatches.",
             ledger.checked_count, ledger.toggle_count, ledger.mismatch_count);
    if (ledger.mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
design/phcc_pkg.sv
design/phcc_step.sv
design/pump_hysteresis_cooldown_controller_top.sv
verif/tb_pump_hysteresis_cooldown_controller_top.sv
